// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Operation codes carried on the input tuser bit
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;  // insert the broadcast entry in order
        logic rem;  // pop the head, shift the chain toward the head
    } spq_ctrl_t;

    // Field widths of the streams
    localparam int FIELD_BITS  = 8;
    localparam int TOTAL_BITS  = 5;
    localparam int S_DATA_BITS = 16;
    localparam int M_DATA_BITS = 32;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIO_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire spq_ctrl_t             ctrl,
    input  wire logic [PRIO_BITS-1:0]  new_prio,
    input  wire logic [FIELD_BITS-1:0] new_char,
    // neighbor toward the head
    input  wire logic                  left_valid,
    input  wire logic                  left_after,
    input  wire logic [PRIO_BITS-1:0]  left_prio,
    input  wire logic [FIELD_BITS-1:0] left_char,
    // neighbor toward the tail
    input  wire logic                  right_valid,
    input  wire logic [PRIO_BITS-1:0]  right_prio,
    input  wire logic [FIELD_BITS-1:0] right_char,
    output logic                       valid,
    output logic                       after,
    output logic [PRIO_BITS-1:0]       prio,
    output logic [FIELD_BITS-1:0]      char_out
);

    logic                  valid_reg, valid_next;
    logic [PRIO_BITS-1:0]  prio_reg, prio_next;
    logic [FIELD_BITS-1:0] char_reg, char_next;

    // New entry belongs behind this slot when ours is less or equal
    assign after = valid_reg && (prio_reg <= new_prio);

    // Choose keep, take new, take left, or take right
    always_comb begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        char_next  = char_reg;
        if (ctrl.rem) begin
            valid_next = right_valid;
            prio_next  = right_prio;
            char_next  = right_char;
        end else if (ctrl.ins && !after) begin
            if (left_after) begin
                valid_next = 1'b1;
                prio_next  = new_prio;
                char_next  = new_char;
            end else begin
                valid_next = left_valid;
                prio_next  = left_prio;
                char_next  = left_char;
            end
        end
    end

    // Occupancy bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        char_reg <= char_next;
    end

    assign valid    = valid_reg;
    assign prio     = prio_reg;
    assign char_out = char_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, count and result register.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue kept sorted in a chain of CAPACITY cells, head in
// cell 0. Each input transfer carries an operation on s_tuser (0 insert,
// 1 remove) and an entry on s_tdata. An insert lands behind every entry of
// lower or equal priority, so ties leave first in, first out; a remove pops
// the head. Every cell compares against the broadcast entry at once, so one
// item is taken per cycle whenever the result register is empty or being
// drained. Every input transfer yields exactly one result transfer, offered
// in the next cycle at the earliest, carrying the popped entry (if any), an
// error bit for a dropped operation (insert when full, remove when empty),
// and the count, empty and full after the operation.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [7:0] item_prio, [15:8] item_char
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    // [0] operation
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] out_valid, [8:1] out_prio, [16:9] out_char, [17] error_flag,
    // [22:18] entry_total, [23] is_empty, [24] is_full, [31:25] zero
    output logic [M_DATA_BITS-1:0]      m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                  s_fire;
    op_t                   op;
    logic [PRIO_BITS-1:0]  new_prio;
    logic [FIELD_BITS-1:0] new_char;
    spq_ctrl_t             ctrl;

    logic [CAPACITY-1:0]   cell_valid;
    logic [CAPACITY-1:0]   cell_after;
    logic [PRIO_BITS-1:0]  cell_prio [CAPACITY];
    logic [FIELD_BITS-1:0] cell_char [CAPACITY];

    logic [CW-1:0] count_reg, count_next;
    logic          is_full_now, is_empty_now;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic                  res_valid, res_err;
    logic [31:0]           head_prio_w, count_w;
    logic [FIELD_BITS-1:0] res_prio, res_char;

    // Accept while the result register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign op       = op_t'(s_tuser);
    assign new_prio = PRIO_BITS'(s_tdata[FIELD_BITS-1:0]);
    assign new_char = s_tdata[2*FIELD_BITS-1:FIELD_BITS];

    assign is_full_now  = (count_reg == CW'(CAPACITY));
    assign is_empty_now = (count_reg == '0);

    // Drop an insert when full and a remove when empty
    assign ctrl.ins = s_fire && (op == OP_INSERT) && !is_full_now;
    assign ctrl.rem = s_fire && (op == OP_REMOVE) && !is_empty_now;

    // Chain of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  l_valid, l_after, r_valid;
        logic [PRIO_BITS-1:0]  l_prio, r_prio;
        logic [FIELD_BITS-1:0] l_char, r_char;

        if (i == 0) begin : g_head
            assign l_valid = 1'b1;
            assign l_after = 1'b1;
            assign l_prio  = '0;
            assign l_char  = '0;
        end else begin : g_mid
            assign l_valid = cell_valid[i-1];
            assign l_after = cell_after[i-1];
            assign l_prio  = cell_prio[i-1];
            assign l_char  = cell_char[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_prio  = '0;
            assign r_char  = '0;
        end else begin : g_body
            assign r_valid = cell_valid[i+1];
            assign r_prio  = cell_prio[i+1];
            assign r_char  = cell_char[i+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_prio    (new_prio),
            .new_char    (new_char),
            .left_valid  (l_valid),
            .left_after  (l_after),
            .left_prio   (l_prio),
            .left_char   (l_char),
            .right_valid (r_valid),
            .right_prio  (r_prio),
            .right_char  (r_char),
            .valid       (cell_valid[i]),
            .after       (cell_after[i]),
            .prio        (cell_prio[i]),
            .char_out    (cell_char[i])
        );
    end

    // Advance the entry count
    always_comb begin
        count_next = count_reg;
        if (ctrl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Build the result word from the head and the updated count
    always_comb begin
        res_valid   = ctrl.rem;
        res_err     = s_fire && !ctrl.ins && !ctrl.rem;
        head_prio_w = 32'(cell_prio[0]);
        count_w     = 32'(count_next);
        res_prio    = res_valid ? head_prio_w[FIELD_BITS-1:0] : '0;
        res_char    = res_valid ? cell_char[0] : '0;
        m_tdata_next = {
            7'b0,
            (count_next == CW'(CAPACITY)),
            (count_next == '0),
            count_w[TOTAL_BITS-1:0],
            res_err,
            res_char,
            res_prio,
            res_valid
        };
    end

    // Hold the result until the transfer completes
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Occupied cells form the count
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupied cells disagree with count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    a_empty_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (op == OP_REMOVE) && is_empty_now |=> m_tvalid && m_tdata[17] && !m_tdata[0])
        else $error("remove on empty queue not flagged");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[1] |-> cell_prio[0] <= cell_prio[1])
        else $error("head entries out of order");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rem |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not lower count");

endmodule

`default_nettype wire

// ===== tb/sv/spq_order_checker.sv =====
// Checker for the sorted priority queue: watches both streams, predicts and compares.
`timescale 1ns / 1ps

module spq_order_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int PRIO_BITS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    // [7:0] item_prio, [15:8] item_char
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    // [0] operation
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    // [0] out_valid, [8:1] out_prio, [16:9] out_char, [17] error_flag,
    // [22:18] entry_total, [23] is_empty, [24] is_full, [31:25] zero
    input  wire logic [M_DATA_BITS-1:0] m_tdata,
    output int                          fail_count,
    output int                          pending
);

    localparam int PRIO_KEEP = (PRIO_BITS < FIELD_BITS) ? PRIO_BITS : FIELD_BITS;
    localparam logic [FIELD_BITS-1:0] PRIO_MASK = FIELD_BITS'((1 << PRIO_KEEP) - 1);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                  popped;
        logic [FIELD_BITS-1:0] prio;
        logic [FIELD_BITS-1:0] chr;
        logic                  dropped;
        logic [TOTAL_BITS-1:0] total;
        logic                  empty;
        logic                  full;
        logic [6:0]            pad;
    } queue_result_t;

    // Mirror of the stored entries, head in slot 0
    logic [FIELD_BITS-1:0] slot_prio [CAPACITY];
    logic [FIELD_BITS-1:0] slot_char [CAPACITY];
    int                    held;

    queue_result_t due_results[$];
    int            fails;

    // Apply one operation to the mirror and return the result it yields
    function automatic queue_result_t apply_queue_op(input op_t op,
                                                     input logic [FIELD_BITS-1:0] prio_in,
                                                     input logic [FIELD_BITS-1:0] chr);
        queue_result_t          res;
        logic [FIELD_BITS-1:0]  prio;
        int                     pos;
        res  = '0;
        prio = prio_in & PRIO_MASK;
        if (op == OP_REMOVE) begin
            if (held == 0) begin
                res.dropped = 1'b1;
            end else begin
                res.popped = 1'b1;
                res.prio   = slot_prio[0];
                res.chr    = slot_char[0];
                for (int i = 1; i < held; i++) begin
                    slot_prio[i-1] = slot_prio[i];
                    slot_char[i-1] = slot_char[i];
                end
                held--;
            end
        end else begin
            if (held >= CAPACITY) begin
                res.dropped = 1'b1;
            end else begin
                // land behind every entry of lower or equal priority
                pos = 0;
                while (pos < held && slot_prio[pos] <= prio)
                    pos++;
                for (int i = held; i > pos; i--) begin
                    slot_prio[i] = slot_prio[i-1];
                    slot_char[i] = slot_char[i-1];
                end
                slot_prio[pos] = prio;
                slot_char[pos] = chr;
                held++;
            end
        end
        res.total = TOTAL_BITS'(held);
        res.empty = (held == 0);
        res.full  = (held >= CAPACITY);
        return res;
    endfunction

    function automatic queue_result_t unpack_result(input logic [M_DATA_BITS-1:0] d);
        queue_result_t r;
        r.popped  = d[0];
        r.prio    = d[8:1];
        r.chr     = d[16:9];
        r.dropped = d[17];
        r.total   = d[22:18];
        r.empty   = d[23];
        r.full    = d[24];
        r.pad     = d[31:25];
        return r;
    endfunction

    // Compare result transfers first, then queue the prediction for a new input transfer
    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        if (!aresetn) begin
            held = 0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (due_results.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected, tdata=%08h",
                                 $realtime, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (got.popped !== want.popped || got.prio !== want.prio ||
                        got.chr !== want.chr || got.dropped !== want.dropped ||
                        got.total !== want.total || got.empty !== want.empty ||
                        got.full !== want.full || got.pad !== want.pad) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("%0t: expected valid=%0d prio=%02h char=%02h err=%0d",
                                     $realtime, want.popped, want.prio, want.chr, want.dropped,
                                     " total=%0d empty=%0d full=%0d pad=%02h",
                                     want.total, want.empty, want.full, want.pad);
                            $display("%0t: actual   valid=%0d prio=%02h char=%02h err=%0d",
                                     $realtime, got.popped, got.prio, got.chr, got.dropped,
                                     " total=%0d empty=%0d full=%0d pad=%02h",
                                     got.total, got.empty, got.full, got.pad);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(apply_queue_op(op_t'(s_tuser), s_tdata[7:0],
                                                     s_tdata[15:8]));
        end
        fail_count <= fails;
        pending    <= due_results.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int RAND_ITEMS = 1500;
    localparam int PHASE_LEN  = 100;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_WAIT  = 20;
    localparam int LIMIT      = 1_000_000;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic                   s_tuser = OP_INSERT;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;

    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;
    int   hold_reqs = 0;
    int   holds_served = 0;

    sorted_priority_queue #(.CAPACITY(CAPACITY), .PRIO_BITS(8)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    spq_order_checker #(.CAPACITY(CAPACITY), .PRIO_BITS(8)) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Result side: ready with random gaps, plus long hold-offs on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (holds_served != hold_reqs) begin
                holds_served <= holds_served + 1;
                m_tready     <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else if (rx_steady || $urandom_range(0, 3) != 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
        end
    end

    // Offer one item and hold it until the transfer happens
    task automatic offer(input op_t op, input logic [7:0] prio, input logic [7:0] chr);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {chr, prio};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!tx_steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    initial begin
        int     insert_pct;
        int     prio_mode;
        op_t    op;
        logic [7:0] prio;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: remove when empty, extremes, ties in arrival order
        offer(OP_REMOVE, 8'h00, 8'h00);
        offer(OP_INSERT, 8'h80, 8'h5A);
        offer(OP_INSERT, 8'hFF, 8'hFF);
        offer(OP_INSERT, 8'h00, 8'h00);
        offer(OP_INSERT, 8'h80, 8'hA5);
        repeat (4) offer(OP_REMOVE, 8'hFF, 8'hFF);
        // Fill to capacity with descending priorities, then insert when full
        for (int i = 0; i < CAPACITY; i++)
            offer(OP_INSERT, 8'(255 - 16 * i), 8'(i * 17));
        offer(OP_INSERT, 8'h01, 8'hC3);

        // Random phases with varying insert bias and priority spread
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                insert_pct = (n / PHASE_LEN % 3 == 0) ? 80 :
                             (n / PHASE_LEN % 3 == 1) ? 20 : 50;
                prio_mode  = $urandom_range(0, 2);
                tx_steady  = ($urandom_range(0, 2) == 0);
                rx_steady  = ($urandom_range(0, 2) == 0);
                if (n / PHASE_LEN % 5 == 2) begin
                    tx_steady = 1'b1;
                    hold_reqs <= hold_reqs + 1;
                end
            end
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
            case (prio_mode)
                0: begin
                    prio = 8'($urandom_range(0, 3));
                end
                1: begin
                    prio = ($urandom_range(0, 1) != 0) ? 8'hFF - 8'($urandom_range(0, 2))
                                                       : 8'($urandom_range(0, 2));
                end
                default: begin
                    prio = 8'($urandom_range(0, 255));
                end
            endcase
            offer(op, prio, 8'($urandom_range(0, 255)));
        end

        // Drain, then allow for late extras
        s_tvalid <= 1'b0;
        rx_steady = 1'b1;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
